@@ src/pc1sc_pkg.sv @@
// pc1sc_pkg: shared types and constants for the 128-bit key byte-stream cipher
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package pc1sc_pkg;

  localparam int unsigned NUM_ROUNDS = 8;
  localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);
  localparam int unsigned KEY_WORDS  = 8;

  localparam logic [15:0] MUL_A = 16'h4e35;
  localparam logic [15:0] MUL_B = 16'h015a;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW     = 2'd1;
  localparam logic [1:0] CFG_DECRYPT_MODE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic                start;     // latch input byte, reload on restart
    logic                round;     // run one keystream round
    logic [ROUND_W-1:0]  round_idx;
    logic                finish;    // mask byte, load output, update key
  } dp_cmd_t;

endpackage

@@ src/pc1sc_ctrl.sv @@
// pc1sc_ctrl: sequencer for the eight keystream rounds and the output handshake
// depends on pc1sc_pkg
`timescale 1ns / 1ps

module pc1sc_ctrl
  import pc1sc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROUND_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.round_idx = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == ROUND_W'(NUM_ROUNDS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait until the output register is free
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/pc1sc_datapath.sv @@
// pc1sc_datapath: key registers, running key, chain registers and one shared round unit
// depends on pc1sc_pkg
`timescale 1ns / 1ps

module pc1sc_datapath
  import pc1sc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic [7:0]  out_result_byte
);

  logic [63:0] key_high_r, key_low_r;
  logic        decrypt_mode_r;

  // running key held as byte pairs, pair i = {byte 2i, byte 2i+1}
  logic [15:0] rk_r [KEY_WORDS];
  logic [15:0] chain_r, scaled_r, word_r, fold_r;
  logic [7:0]  data_r, result_r;

  logic [15:0] w, dx, ax, cx;
  logic [31:0] p_chain, p_wb, p_wa;
  logic [15:0] chain_off;
  logic [7:0]  res, upd;

  // one keystream round
  assign w         = word_r ^ rk_r[cmd.round_idx];
  assign chain_off = chain_r + {{(16 - ROUND_W){1'b0}}, cmd.round_idx};
  assign p_chain   = chain_off * MUL_A;
  assign p_wb      = w * MUL_B;
  assign p_wa      = w * MUL_A;
  assign cx        = p_chain[15:0] + p_wb[15:0];
  assign dx        = cx + scaled_r;
  assign ax        = p_wa[15:0] + 16'd1;

  assign res = data_r ^ fold_r[15:8] ^ fold_r[7:0];
  assign upd = decrypt_mode_r ? res : data_r;

  assign out_result_byte = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r     <= '0;
      key_low_r      <= '0;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_HIGH:     key_high_r     <= cfg_wdata;
        CFG_KEY_LOW:      key_low_r      <= cfg_wdata;
        CFG_DECRYPT_MODE: decrypt_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        rk_r[i] <= '0;
      end
      chain_r  <= '0;
      scaled_r <= '0;
    end else if (cmd.start && in_restart) begin
      for (int i = 0; i < KEY_WORDS / 2; i++) begin
        rk_r[i]                 <= key_high_r[63 - 16 * i -: 16];
        rk_r[i + KEY_WORDS / 2] <= key_low_r[63 - 16 * i -: 16];
      end
      chain_r  <= '0;
      scaled_r <= '0;
    end else if (cmd.round) begin
      chain_r  <= dx;
      scaled_r <= p_wb[15:0];
    end else if (cmd.finish) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        rk_r[i] <= rk_r[i] ^ {upd, upd};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      data_r <= in_data_byte;
      word_r <= '0;
      fold_r <= '0;
    end else if (cmd.round) begin
      word_r <= ax;
      fold_r <= fold_r ^ ax ^ dx;
    end
    if (cmd.finish) begin
      result_r <= res;
    end
  end

endmodule

@@ src/pc1_stream_cipher_128_top.sv @@
// pc1_stream_cipher_128_top: byte-stream cipher with a 128-bit key
// each byte is loaded, run through eight rounds in the single shared round unit
// and finished, and no new byte is taken before it is finished
// a new byte is taken while the previous result still waits in the output register
// reset (rst_n, synchronous) clears the keys, mode, running key and chain registers
// depends on pc1sc_pkg, pc1sc_ctrl, pc1sc_datapath
`timescale 1ns / 1ps

module pc1_stream_cipher_128_top
  import pc1sc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] result_byte
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  dp_cmd_t cmd;

  pc1sc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pc1sc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .in_data_byte    (in_tdata),
    .in_restart      (in_tuser),
    .out_result_byte (out_tdata)
  );

endmodule

@@ verif/tb_pc1_stream_cipher_128_top.sv @@
// tb_pc1_stream_cipher_128_top: self-checking bench for the 128-bit key byte-stream cipher
// predicts every output byte from its own copy of the key schedule and chain registers
// depends on pc1sc_pkg and pc1_stream_cipher_128_top
`timescale 1ns / 1ps

module tb_pc1_stream_cipher_128_top;
  import pc1sc_pkg::*;

  localparam int ITEM_TARGET  = 1050;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  class cipher_scoreboard;
    logic [63:0] key_high_q;
    logic [63:0] key_low_q;
    bit          decrypt_q;
    logic [7:0]  run_key [16];
    logic [15:0] chain_sum;
    logic [15:0] scaled_word;
    logic [7:0]  expected_bytes [$];
    int          errors;

    function new();
      key_high_q  = '0;
      key_low_q   = '0;
      decrypt_q   = 1'b0;
      foreach (run_key[j]) run_key[j] = '0;
      chain_sum   = '0;
      scaled_word = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY_HIGH:     key_high_q = val;
        CFG_KEY_LOW:      key_low_q  = val;
        CFG_DECRYPT_MODE: decrypt_q  = val[0];
        default: ;
      endcase
    endfunction

    // runs the eight keystream rounds for one accepted byte
    function void note_byte(logic [7:0] data, bit restart);
      logic [15:0] word;
      logic [15:0] fold;
      logic [15:0] kw;
      logic [15:0] cx;
      logic [15:0] dx;
      logic [15:0] ax;
      logic [7:0]  res;
      logic [7:0]  upd;
      word = '0;
      fold = '0;
      if (restart) begin
        for (int j = 0; j < 8; j++) begin
          run_key[j]     = key_high_q[63 - 8*j -: 8];
          run_key[8 + j] = key_low_q[63 - 8*j -: 8];
        end
        chain_sum   = '0;
        scaled_word = '0;
      end
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        kw          = {run_key[2*r], run_key[2*r + 1]};
        word        = word ^ kw;
        cx          = (chain_sum + 16'(r)) * MUL_A;
        cx          = cx + word * MUL_B;
        dx          = cx + scaled_word;
        scaled_word = word * MUL_B;
        ax          = word * MUL_A + 16'd1;
        chain_sum   = dx;
        word        = ax;
        fold        = fold ^ ax ^ dx;
      end
      res = data ^ fold[15:8] ^ fold[7:0];
      // key follows the plaintext byte in both directions
      upd = decrypt_q ? res : data;
      foreach (run_key[j]) run_key[j] = run_key[j] ^ upd;
      expected_bytes.push_back(res);
    endfunction

    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        $error("result_byte with no byte pending: expected none, actual %02h", got);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        $error("result_byte mismatch: expected %02h, actual %02h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] data_byte
  logic        in_tuser   = 1'b0; // [0] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] result_byte
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [63:0] cfg_wdata  = '0;

  cipher_scoreboard sb;
  bit  steady      = 1'b0;
  int  items_sent  = 0;
  int  cycle_count = 0;

  pc1_stream_cipher_128_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 33);
  endfunction

  function automatic logic [63:0] pick_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: sample the transaction, then choose ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata);
    out_tready <= rst_n && !idle_roll();
  end

  task automatic send_byte(input logic [7:0] data, input bit restart);
    while (idle_roll()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(data, restart);
    items_sent++;
  endtask

  // sel bit 0 key_high, bit 1 key_low, bit 2 decrypt_mode
  task automatic program_cfg(input bit [2:0] sel, input logic [63:0] hi,
                             input logic [63:0] lo, input bit mode);
    logic [63:0] vals [3];
    logic [1:0]  idxs [3];
    vals = '{hi, lo, {63'd0, mode}};
    idxs = '{CFG_KEY_HIGH, CFG_KEY_LOW, CFG_DECRYPT_MODE};
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= idxs[i];
        cfg_wdata <= vals[i];
        sb.write_reg(idxs[i], vals[i]);
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          n;
    int          phase;
    logic [63:0] hi;
    logic [63:0] lo;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // no restart yet: bytes run on the all-zero reset state
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    settle();

    program_cfg(3'b111, '1, '0, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    settle();

    // switch to decrypt in the middle of a message
    program_cfg(3'b100, '0, '0, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'hff, 1'b0);
    settle();

    // new key mid-message only applies from the next restart
    program_cfg(3'b011, '0, '1, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    settle();

    program_cfg(3'b111, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b1);
    send_byte(8'h80, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      hi = pick_key();
      lo = pick_key();
      program_cfg(3'($urandom_range(7)), hi, lo, 1'($urandom_range(1)));
      steady = (phase == 3);
      n = steady ? 150 : $urandom_range(10, 60);
      // mostly whole messages; some phases continue the previous one
      for (int i = 0; i < n; i++) begin
        send_byte(8'($urandom_range(255)),
                  (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(15) == 0));
      end
      phase++;
    end
    steady = 1'b0;
    settle();

    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
